@@ sv/imu_sample_rotate_rms_defines.svh @@
// Assertion macros for the checker file of this block
`ifndef IMU_SAMPLE_ROTATE_RMS_DEFINES_SVH
`define IMU_SAMPLE_ROTATE_RMS_DEFINES_SVH
// clocked, reset-gated concurrent assertion with a message
`define IMUSRR_ASSERT_MSG(lbl, prop, msg) lbl: assert property ( \
  @(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// same with a fixed message
`define IMUSRR_ASSERT(lbl, prop) `IMUSRR_ASSERT_MSG(lbl, prop, "imusrr check failed")
`endif

@@ sv/imusrr_pkg.sv @@
// Types, codes and helpers shared by the IMU scale/rotate/rms block
package imusrr_pkg;

  localparam logic [2:0] REG_ACC_RECIP  = 3'd0;
  localparam logic [2:0] REG_GYRO_RECIP = 3'd1;
  localparam logic [2:0] REG_MAG_RECIP  = 3'd2;
  localparam logic [2:0] REG_ROW0       = 3'd3;
  localparam logic [2:0] REG_ROW1       = 3'd4;
  localparam logic [2:0] REG_ROW2       = 3'd5;
  localparam logic [2:0] REG_EXP_SERIAL = 3'd6;

  localparam logic [2:0] SS_UPDATED = 3'd3;
  localparam logic [2:0] SS_HOLD    = 3'd4;
  localparam logic [2:0] SS_EXTRAP  = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SERIAL = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [31:0] ACC_RECIP_RST  = 32'd8389;
  localparam logic [31:0] GYRO_RECIP_RST = 32'd8389;
  localparam logic [31:0] MAG_RECIP_RST  = 32'd2517212;
  localparam logic [47:0] ROW0_RST       = 48'h0000_0000_4000;
  localparam logic [47:0] ROW1_RST       = 48'h0000_4000_0000;
  localparam logic [47:0] ROW2_RST       = 48'h4000_0000_0000;

  typedef enum logic [1:0] {
    MUL_SCALE = 2'd0,
    MUL_ROT   = 2'd1,
    MUL_SQ    = 2'd2
  } mul_op_e;

  typedef struct packed {
    logic       accept;
    logic       mul_en;
    mul_op_e    mul_op;
    logic       scale_wr;
    logic       rot_acc;
    logic       sq_load;
    logic       div_step;
    logic       mean_upd;
    logic       sqrt_step;
    logic       sqrt_last;
    logic [1:0] sen;
    logic [1:0] ax;
    logic [1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic reject_in;
    logic rejected;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (x < -50'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/imusrr_ctrl.sv @@
// Sequencer for the IMU scale/rotate/rms block
module imusrr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  imusrr_pkg::stat_t    stat_i,
  output imusrr_pkg::cmd_t     cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCALE = 7'b0000010,
    S_ROT   = 7'b0000100,
    S_SQ    = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_SQRT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic       ph_q, ph_d;
  logic [1:0] sen_q, sen_d;
  logic [1:0] ax_q, ax_d;
  logic [1:0] tap_q, tap_d;
  logic [5:0] it_q, it_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 1'b0;
      sen_q   <= 2'd0;
      ax_q    <= 2'd0;
      tap_q   <= 2'd0;
      it_q    <= 6'd0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      sen_q   <= sen_d;
      ax_q    <= ax_d;
      tap_q   <= tap_d;
      it_q    <= it_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    sen_d   = sen_q;
    ax_d    = ax_q;
    tap_d   = tap_q;
    it_d    = it_q;
    cmd_o           = '0;
    cmd_o.mul_op    = imusrr_pkg::MUL_SCALE;
    cmd_o.sen       = sen_q;
    cmd_o.ax        = ax_q;
    cmd_o.tap       = tap_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          sen_d = 2'd0;
          ax_d  = 2'd0;
          tap_d = 2'd0;
          ph_d  = 1'b0;
          state_d = stat_i.reject_in ? S_OUT : S_SCALE;
        end
      end
      S_SCALE: begin
        if (!ph_q) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_op = imusrr_pkg::MUL_SCALE;
          ph_d = 1'b1;
        end else begin
          cmd_o.scale_wr = 1'b1;
          ph_d = 1'b0;
          if (ax_q == 2'd2) begin
            ax_d    = 2'd0;
            tap_d   = 2'd0;
            state_d = S_ROT;
          end else begin
            ax_d = ax_q + 2'd1;
          end
        end
      end
      S_ROT: begin
        if (!ph_q) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_op = imusrr_pkg::MUL_ROT;
          ph_d = 1'b1;
        end else begin
          cmd_o.rot_acc = 1'b1;
          ph_d = 1'b0;
          if (tap_q == 2'd2) begin
            tap_d = 2'd0;
            if (ax_q == 2'd2) begin
              ax_d    = 2'd0;
              state_d = S_SQ;
            end else begin
              ax_d = ax_q + 2'd1;
            end
          end else begin
            tap_d = tap_q + 2'd1;
          end
        end
      end
      S_SQ: begin
        if (!ph_q) begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_op = imusrr_pkg::MUL_SQ;
          ph_d = 1'b1;
        end else begin
          cmd_o.sq_load = 1'b1;
          ph_d    = 1'b0;
          it_d    = 6'd63;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (it_q == 6'd0) begin
          ph_d    = 1'b0;
          state_d = S_SQRT;
        end else begin
          it_d = it_q - 6'd1;
        end
      end
      S_SQRT: begin
        if (!ph_q) begin
          cmd_o.mean_upd = 1'b1;
          ph_d = 1'b1;
          it_d = 6'd31;
        end else begin
          cmd_o.sqrt_step = 1'b1;
          if (it_q == 6'd0) begin
            cmd_o.sqrt_last = 1'b1;
            ph_d = 1'b0;
            if (ax_q == 2'd2) begin
              state_d = S_OUT;
            end else begin
              ax_d    = ax_q + 2'd1;
              state_d = S_SQ;
            end
          end else begin
            it_d = it_q - 6'd1;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (stat_i.rejected || sen_q == 2'd2) begin
            state_d = S_IDLE;
          end else begin
            sen_d   = sen_q + 2'd1;
            ax_d    = 2'd0;
            tap_d   = 2'd0;
            state_d = S_SCALE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ sv/imusrr_dpath.sv @@
// Datapath: config registers, shared multiplier, divider, square root, state
module imusrr_dpath #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imusrr_pkg::cmd_t    cmd_i,
  output imusrr_pkg::stat_t   stat_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  logic signed [15:0]  raw_i [9],
  input  logic [2:0]          signal_state_i,
  input  logic [63:0]         serial_in_i,
  output logic [1:0]          sensor_kind_o,
  output logic signed [31:0]  value_o [3],
  output logic [31:0]         rms_o [3],
  output logic [1:0]          status_o,
  output logic                last_o
);

  localparam int DW = COUNT_BITS + 1;

  logic [31:0] recip_q [3];
  logic [47:0] row_q [3];
  logic [63:0] exp_serial_q;

  logic [COUNT_BITS-1:0] count_q;
  logic                  checked_q;
  logic [63:0]           mean_q [9];
  logic                  rej_q;
  logic [1:0]            status_q;
  logic [DW-1:0]         divisor_q;

  logic signed [15:0] raw_q [9];
  logic signed [31:0] scaled_q [3];
  logic signed [49:0] acc_q;
  logic signed [31:0] val_q [3];
  logic signed [65:0] prod_q;
  logic               neg_q;
  logic [DW-1:0]      rem_q;
  logic [63:0]        dq_q;
  logic [63:0]        sv_q, res_q, bit_q;
  logic [31:0]        rms_q [3];

  logic               reject_in;
  logic [3:0]         midx;
  logic signed [32:0] mul_a, mul_b;
  logic [47:0]        row_sel;
  logic signed [32:0] vx, vmag;
  logic signed [49:0] scl_t, rot_sum;
  logic [63:0]        sq, m_cur, m_new;
  logic [DW:0]        div_t;
  logic               div_ge;
  logic [63:0]        rb;
  logic               sq_ge;
  logic [63:0]        res_nx;

  assign reject_in = !(signal_state_i == imusrr_pkg::SS_UPDATED ||
                       signal_state_i == imusrr_pkg::SS_HOLD ||
                       signal_state_i == imusrr_pkg::SS_EXTRAP);
  assign stat_o.reject_in = reject_in;
  assign stat_o.rejected  = rej_q;

  assign midx    = 4'(cmd_i.sen) * 4'd3 + 4'(cmd_i.ax);
  assign row_sel = row_q[cmd_i.ax];
  assign vx      = 33'(val_q[cmd_i.ax]);
  assign vmag    = vx[32] ? -vx : vx;
  assign m_cur   = mean_q[midx];

  always_comb begin
    unique case (cmd_i.mul_op)
      imusrr_pkg::MUL_SCALE: begin
        mul_a = 33'(raw_q[4'(cmd_i.sen) * 4'd3 + 4'(cmd_i.ax)]);
        mul_b = $signed({1'b0, recip_q[cmd_i.sen]});
      end
      imusrr_pkg::MUL_ROT: begin
        mul_a = 33'($signed(row_sel[{cmd_i.tap, 4'b0000} +: 16]));
        mul_b = 33'(scaled_q[cmd_i.tap]);
      end
      imusrr_pkg::MUL_SQ: begin
        mul_a = vmag;
        mul_b = vmag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign scl_t   = ($signed(prod_q[49:0]) + 50'sd128) >>> 8;
  assign rot_sum = ((cmd_i.tap == 2'd0) ? 50'sd0 : acc_q) + prod_q[49:0];
  assign sq      = prod_q[63:0];
  assign m_new   = neg_q ? (m_cur - dq_q) : (m_cur + dq_q);

  // restoring divide, one quotient bit per cycle
  assign div_t  = {rem_q, dq_q[63]};
  assign div_ge = div_t >= {1'b0, divisor_q};

  // bit-pair square root, one result bit per cycle
  assign rb     = res_q + bit_q;
  assign sq_ge  = sv_q >= rb;
  assign res_nx = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recip_q[0]   <= imusrr_pkg::ACC_RECIP_RST;
      recip_q[1]   <= imusrr_pkg::GYRO_RECIP_RST;
      recip_q[2]   <= imusrr_pkg::MAG_RECIP_RST;
      row_q[0]     <= imusrr_pkg::ROW0_RST;
      row_q[1]     <= imusrr_pkg::ROW1_RST;
      row_q[2]     <= imusrr_pkg::ROW2_RST;
      exp_serial_q <= '0;
      count_q      <= '0;
      checked_q    <= 1'b0;
      rej_q        <= 1'b0;
      status_q     <= imusrr_pkg::ST_OK;
      divisor_q    <= DW'(1);
      for (int k = 0; k < 9; k++) begin
        mean_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          imusrr_pkg::REG_ACC_RECIP:  recip_q[0]   <= cfg_data_i[31:0];
          imusrr_pkg::REG_GYRO_RECIP: recip_q[1]   <= cfg_data_i[31:0];
          imusrr_pkg::REG_MAG_RECIP:  recip_q[2]   <= cfg_data_i[31:0];
          imusrr_pkg::REG_ROW0:       row_q[0]     <= cfg_data_i[47:0];
          imusrr_pkg::REG_ROW1:       row_q[1]     <= cfg_data_i[47:0];
          imusrr_pkg::REG_ROW2:       row_q[2]     <= cfg_data_i[47:0];
          imusrr_pkg::REG_EXP_SERIAL: exp_serial_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        rej_q <= reject_in;
        if (!reject_in) begin
          divisor_q <= DW'({1'b0, count_q}) + DW'(1);
          if (!(&count_q)) begin
            count_q <= count_q + COUNT_BITS'(1);
          end
          status_q <= imusrr_pkg::ST_OK;
          if (serial_in_i != 64'd0) begin
            checked_q <= 1'b1;
            if (!checked_q && serial_in_i != exp_serial_q) begin
              status_q <= imusrr_pkg::ST_SERIAL;
            end
          end
        end
      end
      if (cmd_i.mean_upd) begin
        mean_q[midx] <= m_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      raw_q <= raw_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.scale_wr) begin
      scaled_q[cmd_i.ax] <= imusrr_pkg::sat32(scl_t);
    end
    if (cmd_i.rot_acc) begin
      acc_q <= rot_sum;
      if (cmd_i.tap == 2'd2) begin
        val_q[cmd_i.ax] <= imusrr_pkg::sat32((rot_sum + 50'sd8192) >>> 14);
      end
    end
    if (cmd_i.sq_load) begin
      neg_q <= sq < m_cur;
      dq_q  <= (sq < m_cur) ? (m_cur - sq) : (sq - m_cur);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? DW'(div_t - {1'b0, divisor_q}) : div_t[DW-1:0];
      dq_q  <= {dq_q[62:0], div_ge};
    end
    if (cmd_i.mean_upd) begin
      sv_q  <= m_new;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end
    if (cmd_i.sqrt_step) begin
      if (sq_ge) begin
        sv_q <= sv_q - rb;
      end
      res_q <= res_nx;
      bit_q <= bit_q >> 2;
      if (cmd_i.sqrt_last) begin
        rms_q[cmd_i.ax] <= res_nx[31:0];
      end
    end
  end

  assign sensor_kind_o = rej_q ? 2'd0 : cmd_i.sen;
  assign status_o      = rej_q ? imusrr_pkg::ST_REJECT : status_q;
  assign last_o        = rej_q || (cmd_i.sen == 2'd2);
  for (genvar g = 0; g < 3; g++) begin : g_out
    assign value_o[g] = rej_q ? 32'sd0 : val_q[g];
    assign rms_o[g]   = rej_q ? 32'd0 : rms_q[g];
  end

endmodule

@@ sv/imu_sample_rotate_rms.sv @@
// Top level: IMU axis scaling, mounting rotation and running rms
// Usage:
// - Input channel in_valid_i/in_stall_o carries one IMU message: nine raw
//   axes, the signal state and the serial number. One message at a time;
//   in_stall_o is low only while the block is idle.
// - Output channel out_valid_o/out_stall_i gives three result items per
//   message (accelerometer, gyro, magnetometer), last_o on the third. A
//   message with a rejected signal state gives one item, status rejected.
// - Per sensor: scaling and rotation on the shared multiplier, then per axis
//   squaring, a bit-serial divide by the sample count and a bit-serial square
//   root. A rejected message gives its item the cycle after acceptance.
// - A stalled result holds on the ports; the block waits with it.
// - Reset loads the default scales and identity matrix, clears the sample
//   count, the mean squares and the serial check flag.
// - Config port cfg_valid_i/cfg_ready_o is always ready; write it only idle.
module imu_sample_rotate_rms #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] raw_acc_x_i,
  input  logic signed [15:0] raw_acc_y_i,
  input  logic signed [15:0] raw_acc_z_i,
  input  logic signed [15:0] raw_gyro_x_i,
  input  logic signed [15:0] raw_gyro_y_i,
  input  logic signed [15:0] raw_gyro_z_i,
  input  logic signed [15:0] raw_mag_x_i,
  input  logic signed [15:0] raw_mag_y_i,
  input  logic signed [15:0] raw_mag_z_i,
  input  logic [2:0]         signal_state_i,
  input  logic [63:0]        serial_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         sensor_kind_o,
  output logic signed [31:0] value_x_o,
  output logic signed [31:0] value_y_o,
  output logic signed [31:0] value_z_o,
  output logic [31:0]        rms_x_o,
  output logic [31:0]        rms_y_o,
  output logic [31:0]        rms_z_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  imusrr_pkg::cmd_t   cmd;
  imusrr_pkg::stat_t  stat;
  logic signed [15:0] raw [9];
  logic signed [31:0] value [3];
  logic [31:0]        rms [3];

  assign cfg_ready_o = 1'b1;

  assign raw[0] = raw_acc_x_i;
  assign raw[1] = raw_acc_y_i;
  assign raw[2] = raw_acc_z_i;
  assign raw[3] = raw_gyro_x_i;
  assign raw[4] = raw_gyro_y_i;
  assign raw[5] = raw_gyro_z_i;
  assign raw[6] = raw_mag_x_i;
  assign raw[7] = raw_mag_y_i;
  assign raw[8] = raw_mag_z_i;

  imusrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  imusrr_dpath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .raw_i          (raw),
    .signal_state_i (signal_state_i),
    .serial_in_i    (serial_in_i),
    .sensor_kind_o  (sensor_kind_o),
    .value_o        (value),
    .rms_o          (rms),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  assign value_x_o = value[0];
  assign value_y_o = value[1];
  assign value_z_o = value[2];
  assign rms_x_o   = rms[0];
  assign rms_y_o   = rms[1];
  assign rms_z_o   = rms[2];

endmodule

@@ sv/imusrr_checker.sv @@
// Port-level checks for the IMU scale/rotate/rms block, bound to the top
`include "imu_sample_rotate_rms_defines.svh"

module imusrr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] sensor_kind_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  logic reject_out;

  assign reject_out = out_valid_o && (status_o == imusrr_pkg::ST_REJECT);

  `IMUSRR_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)
  `IMUSRR_ASSERT(a_busy_with_result, out_valid_o |-> in_stall_o)
  `IMUSRR_ASSERT(a_more_to_come, out_valid_o && !out_stall_i && !last_o |=> in_stall_o)
  `IMUSRR_ASSERT(a_reject_single, reject_out |-> last_o && sensor_kind_o == 2'd0)

endmodule

bind imu_sample_rotate_rms imusrr_checker u_imusrr_checker (.*);
